// ===== hdl/assert_macros.svh =====
// assertion macros used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while in reset
`define GKG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// plain implication form
`define GKG_ASSERT_IMP(lbl, ante, cons, msg) \
  `GKG_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

// ===== hdl/gkg_pkg.sv =====
// types, constants and exponent table for the gaussian kernel generator
package gkg_pkg;

  localparam int MAX_SIDE_1D_DEF = 63;
  localparam int MAX_SIDE_2D_DEF = 7;
  localparam int WEIGHT_FRAC_BITS_DEF = 16;
  localparam int STORE_DEPTH = 63;
  localparam int RAW_W = 24;
  localparam int EXP_BITS = 21;

  typedef struct packed {
    logic        kind;
    logic [15:0] sigma;
  } in_t;

  typedef struct packed {
    logic [16:0] weight;
    logic [5:0]  position;
    logic [5:0]  kernel_size;
    logic        clamped;
    logic        last;
  } out_t;

  typedef logic [31:0] exp_tab_t [0:EXP_BITS-1];

  // shift-subtract quotient of a 64-bit value by a small term index
  function automatic longint unsigned div_small(longint unsigned num, int unsigned den);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      if (r >= 64'(den)) begin
        r = r - 64'(den);
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // exp(-2^(i-16)) in q32 from the alternating series, upper entries by squaring
  function automatic exp_tab_t build_exp_tab();
    exp_tab_t        tab;
    longint unsigned term;
    longint unsigned acc;
    longint unsigned sq;
    int              shift;
    tab = '{default: '0};
    for (int i = 0; i <= 16; i++) begin
      shift = 16 - i;
      term = 64'd1 << 60;
      acc = term;
      for (int n = 1; n < 64; n++) begin
        term = div_small(term >> shift, 32'(n));
        if (term == 0) break;
        if (n[0]) acc = acc - term;
        else acc = acc + term;
      end
      tab[i] = 32'((acc + (64'd1 << 27)) >> 28);
    end
    for (int i = 17; i < EXP_BITS; i++) begin
      sq = longint'(tab[i-1]) * longint'(tab[i-1]);
      tab[i] = 32'((sq + (64'd1 << 31)) >> 32);
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

// ===== hdl/gaussian_kernel_generator_core.sv =====
// normalized gaussian kernel generator top level
//
//  port group | dir | payload           | handshake
//  in_        | in  | gkg_pkg::in_t     | in_valid / in_ready
//  out_       | out | gkg_pkg::out_t    | out_valid / out_ready
//
// one request at a time; a setup state, then per weight the raw value is built by prep, t division,
// 21 exponent multiply steps (each a multiply and a rounding state), final round and write;
// prep writes directly when the weight is the centre or underflows. Then per weight a read,
// normalizing division and handoff follow; kernel time is set by the bit-serial units and out stalls.
// rst_n clears control state; the raw weight ram needs no clearing
// a stalled out word holds and the block waits for it before going on
module gaussian_kernel_generator_core #(
  parameter int MAX_SIDE_1D = gkg_pkg::MAX_SIDE_1D_DEF,
  parameter int MAX_SIDE_2D = gkg_pkg::MAX_SIDE_2D_DEF,
  parameter int WEIGHT_FRAC_BITS = gkg_pkg::WEIGHT_FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  gkg_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output gkg_pkg::out_t out_data
);

  localparam int H1 = (MAX_SIDE_1D - 1) / 2;
  localparam int H2 = (MAX_SIDE_2D - 1) / 2;
  localparam int NUMW = gkg_pkg::RAW_W + WEIGHT_FRAC_BITS + 1;
  localparam int NCW = $clog2(NUMW + 1);
  localparam int AW = $clog2(gkg_pkg::STORE_DEPTH);

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b00000000001,
    ST_SETUP = 11'b00000000010,
    ST_PREP  = 11'b00000000100,
    ST_DIV   = 11'b00000001000,
    ST_EXPM  = 11'b00000010000,
    ST_EXPR  = 11'b00000100000,
    ST_FIN   = 11'b00001000000,
    ST_WR    = 11'b00010000000,
    ST_RD    = 11'b00100000000,
    ST_QDIV  = 11'b01000000000,
    ST_OUT   = 11'b10000000000
  } state_t;

  state_t state_r;

  logic        kind_r;
  logic [15:0] sigma_r;
  logic [31:0] sig2_r;
  logic [4:0]  half_r;
  logic [5:0]  side_r;
  logic [5:0]  count_r;
  logic        clamped_r;
  logic [5:0]  k_r;
  logic [5:0]  row_r;
  logic [5:0]  col_r;
  logic [31:0] sum_r;
  logic [32:0] rem_r;
  logic [4:0]  step_r;
  logic [20:0] t_r;
  logic [31:0] acc_r;
  logic        one_r;
  logic [63:0] prod_r;
  logic [23:0] raw_r;
  logic [NUMW-1:0] num_r;
  logic [NUMW-1:0] quo_r;
  logic [NCW-1:0]  qcnt_r;
  logic            rd_wait_r;
  gkg_pkg::out_t   out_r;
  logic            out_valid_r;

  // request geometry
  logic [17:0] v3;
  logic [5:0]  half_raw;
  logic [11:0] r12;
  logic [5:0]  half_c;
  logic        clamp_c;
  logic [5:0]  side_c;
  logic [11:0] sq_c;

  always_comb begin
    v3 = 18'(sigma_r) * 18'd3;
    r12 = v3[11:0];
    if (!kind_r) begin
      half_raw = 6'((v3 + 18'd4095) >> 12);
      clamp_c = half_raw > 6'(H1);
      half_c = clamp_c ? 6'(H1) : half_raw;
    end else begin
      half_raw = v3[17:12];
      if (r12 > 12'h800 || (r12 == 12'h800 && half_raw[0])) begin
        half_raw = half_raw + 6'd1;
      end
      clamp_c = half_raw > 6'(H2);
      half_c = clamp_c ? 6'(H2) : half_raw;
    end
    side_c = {half_c[4:0], 1'b1};
    sq_c = 12'(side_c) * 12'(side_c);
  end

  // squared distance of the current position
  logic [5:0]  dr;
  logic [5:0]  dc;
  logic [10:0] d2;
  logic [32:0] d2_sh;

  always_comb begin
    dr = (row_r >= 6'(half_r)) ? row_r - 6'(half_r) : 6'(half_r) - row_r;
    dc = (col_r >= 6'(half_r)) ? col_r - 6'(half_r) : 6'(half_r) - col_r;
    d2 = 11'(dr) * 11'(dr) + 11'(dc) * 11'(dc);
    d2_sh = 33'(d2) << 18;
  end

  logic [32:0] rem2;
  logic        div_ge;
  assign rem2 = {rem_r[31:0], 1'b0};
  assign div_ge = rem2 >= {1'b0, sig2_r};

  logic [4:0]  exp_idx;
  logic [31:0] tab_val;
  assign exp_idx = 5'(gkg_pkg::EXP_BITS - 1) - step_r;
  assign tab_val = gkg_pkg::EXP_TAB[exp_idx];

  logic [64:0] prod_rnd;
  logic [32:0] acc_rnd;
  assign prod_rnd = 65'(prod_r) + (65'd1 << 31);
  assign acc_rnd = 33'(acc_r) + 33'd256;

  logic [32:0] qrem2;
  logic        q_ge;
  assign qrem2 = {rem_r[31:0], num_r[NUMW-1]};
  assign q_ge = qrem2 >= {1'b0, sum_r};

  // raw weight store
  logic        ram_we;
  logic [23:0] ram_rdata;

  assign ram_we = (state_r == ST_WR);

  gkg_ram #(
    .WIDTH(gkg_pkg::RAW_W),
    .DEPTH(gkg_pkg::STORE_DEPTH)
  ) u_raw_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(k_r[AW-1:0]),
    .wdata(raw_r),
    .raddr(k_r[AW-1:0]),
    .rdata(ram_rdata)
  );

  logic last_pos;
  assign last_pos = (k_r == count_r - 6'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_valid_r <= 1'b0;
      sum_r <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            kind_r <= in_data.kind;
            sigma_r <= in_data.sigma;
            state_r <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          half_r <= half_c[4:0];
          side_r <= side_c;
          clamped_r <= clamp_c;
          count_r <= kind_r ? ((sq_c > 12'(gkg_pkg::STORE_DEPTH)) ?
                     6'(gkg_pkg::STORE_DEPTH) : sq_c[5:0]) : side_c;
          sig2_r <= 32'(sigma_r) * 32'(sigma_r);
          k_r <= '0;
          row_r <= kind_r ? 6'd0 : half_c;
          col_r <= '0;
          sum_r <= '0;
          state_r <= ST_PREP;
        end
        ST_PREP: begin
          if (d2 == 11'd0) begin
            raw_r <= 24'h800000;
            state_r <= ST_WR;
          end else if (sig2_r == 32'd0 || d2_sh >= {1'b0, sig2_r}) begin
            raw_r <= '0;
            state_r <= ST_WR;
          end else begin
            rem_r <= d2_sh;
            step_r <= 5'(gkg_pkg::EXP_BITS - 1);
            t_r <= '0;
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem_r <= div_ge ? rem2 - {1'b0, sig2_r} : rem2;
          t_r <= {t_r[19:0], div_ge};
          if (step_r == 5'd0) begin
            step_r <= 5'(gkg_pkg::EXP_BITS - 1);
            one_r <= 1'b1;
            acc_r <= '0;
            state_r <= ST_EXPM;
          end else begin
            step_r <= step_r - 5'd1;
          end
        end
        ST_EXPM: begin
          prod_r <= 64'(acc_r) * 64'(tab_val);
          state_r <= ST_EXPR;
        end
        ST_EXPR: begin
          if (t_r[exp_idx]) begin
            acc_r <= one_r ? tab_val : prod_rnd[63:32];
            one_r <= 1'b0;
          end
          if (step_r == 5'd0) begin
            state_r <= ST_FIN;
          end else begin
            step_r <= step_r - 5'd1;
            state_r <= ST_EXPM;
          end
        end
        ST_FIN: begin
          raw_r <= one_r ? 24'h800000 : acc_rnd[32:9];
          state_r <= ST_WR;
        end
        ST_WR: begin
          sum_r <= sum_r + 32'(raw_r);
          if (last_pos) begin
            k_r <= '0;
            rd_wait_r <= 1'b0;
            state_r <= ST_RD;
          end else begin
            k_r <= k_r + 6'd1;
            if (kind_r && col_r == side_r - 6'd1) begin
              col_r <= '0;
              row_r <= row_r + 6'd1;
            end else begin
              col_r <= col_r + 6'd1;
            end
            state_r <= ST_PREP;
          end
        end
        ST_RD: begin
          // with rd_wait_r low the read is issued; with it high the registered data is taken
          if (!rd_wait_r) begin
            rd_wait_r <= 1'b1;
          end else begin
            num_r <= (NUMW'(ram_rdata) << WEIGHT_FRAC_BITS) + NUMW'(sum_r >> 1);
            rem_r <= '0;
            quo_r <= '0;
            qcnt_r <= NCW'(NUMW);
            state_r <= ST_QDIV;
          end
        end
        ST_QDIV: begin
          if (qcnt_r == '0) begin
            out_r.weight <= (sum_r == 32'd0) ? 17'd0 : quo_r[16:0];
            out_r.position <= k_r;
            out_r.kernel_size <= side_r;
            out_r.clamped <= clamped_r;
            out_r.last <= last_pos;
            out_valid_r <= 1'b1;
            state_r <= ST_OUT;
          end else begin
            rem_r <= q_ge ? qrem2 - {1'b0, sum_r} : qrem2;
            quo_r <= {quo_r[NUMW-2:0], q_ge};
            num_r <= num_r << 1;
            qcnt_r <= qcnt_r - NCW'(1);
          end
        end
        ST_OUT: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
            if (out_r.last) begin
              state_r <= ST_IDLE;
            end else begin
              k_r <= k_r + 6'd1;
              rd_wait_r <= 1'b0;
              state_r <= ST_RD;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data = out_r;

`include "assert_macros.svh"

  `GKG_ASSERT_IMP(a_out_state, out_valid, state_r == ST_OUT, "out word outside output state")
  `GKG_ASSERT_IMP(a_no_overlap, in_ready, !out_valid, "input taken while word pending")
  `GKG_ASSERT_IMP(a_pos_range, out_valid, out_data.position < count_r, "position beyond count")
  `GKG_ASSERT_IMP(a_last_pos, out_valid && out_data.last,
                  out_data.position == count_r - 6'd1, "last flag on wrong position")

endmodule

// ===== hdl/gkg_ram.sv =====
// generic single-port-write ram with registered read
module gkg_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 63
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== tb/tb_gaussian_kernel_generator_core.sv =====
// self-checking testbench for the gaussian kernel weight generator
`timescale 1ns / 1ps

module tb_gaussian_kernel_generator_core;

  localparam int      WFRAC      = 16;
  localparam int      HMAX_1D    = (63 - 1) / 2;
  localparam int      HMAX_2D    = (7 - 1) / 2;
  localparam int      NUM_RANDOM = 120;
  localparam int      QUIET_TAIL = 20;
  localparam int      SETTLE     = 8000;
  localparam longint  CYCLE_CAP  = 4000000;
  localparam bit      KIND_1D    = 1'b0;
  localparam bit      KIND_2D    = 1'b1;

  typedef struct packed {
    gkg_pkg::in_t        req;
    logic                typed;
    logic [1:0]          n;
    gkg_pkg::out_t [2:0] w;
  } stim_row_t;

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_ready;
  gkg_pkg::in_t  in_data;
  logic          out_valid;
  logic          out_ready;
  gkg_pkg::out_t out_data;

  bit [63:0]     e_tab [0:20];
  gkg_pkg::out_t weight_q [$];
  int        mismatches;
  int        words_seen;
  int        reqs_sent;
  int        runs_1d;
  int        runs_2d;
  int        runs_clamped;
  longint    cycles;
  bit        quiet;
  int        rdy_cnt;

  gaussian_kernel_generator_core i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // exp(-2^(i-16)) in q32: series for the low entries, squares above
  function automatic void fill_exp_table();
    bit [63:0] term;
    bit [63:0] acc;
    for (int i = 0; i <= 16; i++) begin
      term = 64'd1 << 60;
      acc  = term;
      for (int n = 1; n < 64; n++) begin
        term = (term >> (16 - i)) / 64'(n);
        if (term == 0) break;
        if (n[0]) acc = acc - term;
        else acc = acc + term;
      end
      e_tab[i] = (acc + (64'd1 << 27)) >> 28;
    end
    for (int i = 17; i <= 20; i++) begin
      e_tab[i] = (e_tab[i-1] * e_tab[i-1] + (64'd1 << 31)) >> 32;
    end
  endfunction

  function automatic bit [23:0] gauss_raw(bit [31:0] d2, bit [63:0] sig2);
    bit [63:0] t;
    bit [63:0] acc;
    if (d2 == 0) return 24'h800000;
    if (sig2 == 0) return 24'd0;
    t = ({32'd0, d2} << 39) / sig2;
    if ((t >> 21) != 0) return 24'd0;
    acc = 64'd1 << 32;
    for (int i = 0; i < 21; i++) begin
      if (t[i]) acc = (acc * e_tab[i] + (64'd1 << 31)) >> 32;
    end
    return 24'((acc + 64'd256) >> 9);
  endfunction

  // queue the normalized weights that one request produces
  function automatic void queue_kernel_weights(gkg_pkg::in_t r);
    bit [31:0] v;
    bit [31:0] half;
    bit [31:0] hmax;
    bit [31:0] side;
    bit [31:0] cnt;
    bit [31:0] sum;
    bit [31:0] d2;
    bit [63:0] sig2;
    bit [63:0] w;
    bit        clip;
    int        x;
    int        y;
    bit [23:0] raw [0:62];
    gkg_pkg::out_t o;
    v    = 3 * r.sigma;
    sig2 = 64'(r.sigma) * 64'(r.sigma);
    clip = 1'b0;
    if (r.kind == KIND_1D) begin
      half = (v + 32'd4095) >> 12;
      hmax = HMAX_1D;
    end else begin
      half = v >> 12;
      // round to nearest, ties to even
      if (v[11:0] > 12'h800 || (v[11:0] == 12'h800 && half[0])) half++;
      hmax = HMAX_2D;
    end
    if (half > hmax) begin
      half = hmax;
      clip = 1'b1;
    end
    side = 2 * half + 1;
    cnt  = (r.kind == KIND_2D) ? side * side : side;
    if (cnt > 63) cnt = 63;
    sum = 0;
    for (int k = 0; k < cnt; k++) begin
      if (r.kind == KIND_1D) begin
        x  = k - int'(half);
        d2 = x * x;
      end else begin
        x  = k / int'(side) - int'(half);
        y  = k % int'(side) - int'(half);
        d2 = x * x + y * y;
      end
      raw[k] = gauss_raw(d2, sig2);
      sum    = sum + raw[k];
    end
    for (int k = 0; k < cnt; k++) begin
      w = (sum != 0) ? ((64'(raw[k]) << WFRAC) + 64'(sum / 2)) / 64'(sum) : 64'd0;
      o.weight      = w[16:0];
      o.position    = k[5:0];
      o.kernel_size = side[5:0];
      o.clamped     = clip;
      o.last        = (k + 1 == cnt);
      weight_q.push_back(o);
    end
    if (r.kind == KIND_1D) runs_1d++;
    else runs_2d++;
    if (clip) runs_clamped++;
  endfunction

  function automatic gkg_pkg::out_t word_of(int wt, int pos, int size, bit clp, bit lst);
    gkg_pkg::out_t o;
    o.weight      = 17'(wt);
    o.position    = 6'(pos);
    o.kernel_size = 6'(size);
    o.clamped     = clp;
    o.last        = lst;
    return o;
  endfunction

  stim_row_t directed [$];

  function automatic void add_row(bit k, int s);
    stim_row_t row;
    row        = '0;
    row.req    = '{kind: k, sigma: 16'(s)};
    directed.push_back(row);
  endfunction

  function automatic void build_directed();
    stim_row_t row;
    // sigma zero gives a single weight of 1.0
    row = '0; row.req = '{kind: KIND_1D, sigma: 16'd0}; row.typed = 1'b1; row.n = 2'd1;
    row.w[0] = word_of(65536, 0, 1, 1'b0, 1'b1);
    directed.push_back(row);
    row.req.kind = KIND_2D;
    directed.push_back(row);
    // tiny sigma in 2d rounds to a one-weight kernel
    row.req.sigma = 16'd1;
    directed.push_back(row);
    // tiny sigma in 1d: off-centre weights underflow
    row = '0; row.req = '{kind: KIND_1D, sigma: 16'd1}; row.typed = 1'b1; row.n = 2'd3;
    row.w[0] = word_of(0, 0, 3, 1'b0, 1'b0);
    row.w[1] = word_of(65536, 1, 3, 1'b0, 1'b0);
    row.w[2] = word_of(0, 2, 3, 1'b0, 1'b1);
    directed.push_back(row);
    add_row(KIND_1D, 16'hFFFF);
    add_row(KIND_2D, 16'hFFFF);
    add_row(KIND_1D, 16'h1000);
    add_row(KIND_2D, 16'h1000);
    add_row(KIND_2D, 16'h0800);  // tie, odd half rounds up
    add_row(KIND_2D, 16'h1800);  // tie, even half stays, then clamps
    add_row(KIND_2D, 16'h0801);
    add_row(KIND_2D, 16'h07FF);
    add_row(KIND_1D, 16'h5555);
    add_row(KIND_1D, 16'h5556);
    add_row(KIND_1D, 16'h0155);
    add_row(KIND_1D, 16'h0400);
    add_row(KIND_2D, 16'h0400);
    add_row(KIND_1D, 16'hAAAA);
    add_row(KIND_2D, 16'h5555);
    add_row(KIND_1D, 16'h8000);
  endfunction

  task automatic send_request(gkg_pkg::in_t r, bit may_idle);
    int gap;
    if (may_idle && $urandom_range(0, 2) == 0) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    reqs_sent++;
  endtask

  // receiver stalls in random bursts, with long ready stretches mixed in
  always @(posedge clk) begin
    if (!rst_n || quiet) begin
      out_ready <= 1'b1;
      rdy_cnt   <= 0;
    end else if (rdy_cnt > 0) begin
      rdy_cnt <= rdy_cnt - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_ready <= 1'b0;
      rdy_cnt   <= $urandom_range(1, 6);
    end else begin
      out_ready <= 1'b1;
      rdy_cnt   <= $urandom_range(1, 40);
    end
  end

  always @(posedge clk) begin
    gkg_pkg::out_t want;
    if (rst_n && out_valid && out_ready) begin
      words_seen++;
      if (weight_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: %p", out_data);
      end else begin
        want = weight_q.pop_front();
        if (out_data.weight !== want.weight || out_data.position !== want.position ||
            out_data.kernel_size !== want.kernel_size ||
            out_data.clamped !== want.clamped || out_data.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("word mismatch: expected %p, got %p", want, out_data);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    gkg_pkg::in_t r;
    int  pick;
    int  drain;
    mismatches = 0;
    words_seen = 0;
    reqs_sent  = 0;
    runs_1d    = 0;
    runs_2d    = 0;
    runs_clamped = 0;
    cycles     = 0;
    quiet      = 1'b0;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    out_ready  = 1'b1;
    fill_exp_table();
    build_directed();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      send_request(directed[i].req, 1'b1);
      if (directed[i].typed) begin
        for (int j = 0; j < directed[i].n; j++) weight_q.push_back(directed[i].w[j]);
        if (directed[i].req.kind == KIND_1D) runs_1d++;
        else runs_2d++;
      end else begin
        queue_kernel_weights(directed[i].req);
      end
    end

    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i == NUM_RANDOM / 2) begin
        // hold off until the block has drained every word
        in_valid <= 1'b0;
        while (weight_q.size() != 0) @(posedge clk);
        @(posedge clk);
      end
      if (i == NUM_RANDOM - QUIET_TAIL) quiet = 1'b1;
      r.kind = $urandom_range(0, 1);
      pick   = $urandom_range(0, 99);
      // mostly small sigmas keep kernels short; a few use the full range
      if (pick < 5) r.sigma = 16'd0;
      else if (pick < 15) r.sigma = 16'($urandom);
      else r.sigma = 16'($urandom_range(1, 16'h1800));
      send_request(r, !quiet);
      queue_kernel_weights(r);
    end
    in_valid <= 1'b0;

    while (weight_q.size() != 0) @(posedge clk);
    drain = 0;
    while (drain < SETTLE) begin
      @(posedge clk);
      drain++;
    end

    $display("%0d requests (%0d 1d, %0d 2d, %0d clamped), %0d weight words checked",
             reqs_sent, runs_1d, runs_2d, runs_clamped, words_seen);
    if (mismatches == 0 && weight_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d words never arrived", mismatches, weight_q.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
